>>> rtl/ymr_pkg.sv
package ymr_pkg;

  // Default frame geometry and register reset values
  localparam int unsigned DATA_BYTES    = 128;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] CANCEL_RESET  = 16'd100;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_INDEX_W   = 1;

  // Protocol bytes
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_CAN = 8'h18;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_SESSION = 2'd2
  } ymr_op_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PACKET_TIMEOUT = 1'b0,
    REG_CANCEL_WAIT    = 1'b1
  } ymr_reg_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_EOT     = 3'd2,
    ST_CANCEL  = 3'd3,
    ST_ERROR   = 3'd4,
    ST_SEQ     = 3'd5,
    ST_CRC     = 3'd6
  } ymr_status_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_CAN    = 2'd2
  } ymr_phase_e;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_SESSION = 2'd2
  } ymr_cmd_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } ymr_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    ymr_status_e status_code;
    logic [7:0]  block_number;
  } ymr_out_t;

  // Classified item handed from the front to the engine
  typedef struct packed {
    ymr_cmd_e   kind;
    logic [7:0] rx_byte;
    logic       is_soh;
    logic       is_eot;
    logic       is_can;
  } ymr_cmd_t;

  localparam int unsigned CMD_W = $bits(ymr_cmd_t);
  localparam int unsigned OUT_W = $bits(ymr_out_t);

  // CRC-16/XMODEM over one byte, MSB first
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/ymr_fifo.sv
module ymr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/ymr_front.sv
module ymr_front (
  input  ymr_pkg::ymr_in_t  item_i,
  output logic              cmd_valid_o,
  output ymr_pkg::ymr_cmd_t cmd_o
);

  // Decode operation and pre-classify the header bytes
  always_comb begin
    cmd_valid_o    = 1'b1;
    cmd_o.rx_byte  = item_i.rx_byte;
    cmd_o.is_soh   = (item_i.rx_byte == ymr_pkg::BYTE_SOH);
    cmd_o.is_eot   = (item_i.rx_byte == ymr_pkg::BYTE_EOT);
    cmd_o.is_can   = (item_i.rx_byte == ymr_pkg::BYTE_CAN);
    cmd_o.kind     = ymr_pkg::CMD_BYTE;
    unique case (item_i.operation)
      ymr_pkg::OP_BYTE:    cmd_o.kind = ymr_pkg::CMD_BYTE;
      ymr_pkg::OP_TICK:    cmd_o.kind = ymr_pkg::CMD_TICK;
      ymr_pkg::OP_SESSION: cmd_o.kind = ymr_pkg::CMD_SESSION;
      default:             cmd_valid_o = 1'b0;  // unused code is dropped
    endcase
  end

endmodule

>>> rtl/ymr_back.sv
module ymr_back #(
  parameter int unsigned DataBytes = ymr_pkg::DATA_BYTES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ymr_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [ymr_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 cmd_empty_i,
  input  ymr_pkg::ymr_cmd_t                    cmd_i,
  output logic                                 cmd_pop_o,
  input  logic                                 res_full_i,
  output logic                                 res_push_o,
  output ymr_pkg::ymr_out_t                    res_o
);

  localparam int unsigned PosW = $clog2(DataBytes + 5);
  localparam logic [PosW-1:0] PosSeen  = PosW'(1);
  localparam logic [PosW-1:0] PosInv   = PosW'(2);
  localparam logic [PosW-1:0] PosCrcHi = PosW'(DataBytes + 3);
  localparam logic [PosW-1:0] PosCrcLo = PosW'(DataBytes + 4);

  logic [15:0] timeout_q, cancel_q;

  ymr_pkg::ymr_phase_e phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]  expected_q, expected_d;
  logic [7:0]  seen_q, seen_d;
  logic        inv_ok_q, inv_ok_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  sum_q, sum_d;
  logic        matched_q, matched_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic        fire, clear, start_body, start_can, emit, seq_bad;
  logic [15:0] elapsed_inc;
  ymr_pkg::ymr_status_e code;

  assign fire      = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o = fire;

  // Datapath and result
  always_comb begin
    pos_d       = pos_q;
    expected_d  = expected_q;
    seen_d      = seen_q;
    inv_ok_d    = inv_ok_q;
    crc_d       = crc_q;
    sum_d       = sum_q;
    matched_d   = matched_q;
    crc_hi_d    = crc_hi_q;
    elapsed_d   = elapsed_q;
    clear       = 1'b0;
    start_body  = 1'b0;
    start_can   = 1'b0;
    emit        = 1'b0;
    code        = ymr_pkg::ST_OK;
    res_push_o  = 1'b0;
    res_o       = '0;
    elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
    seq_bad     = (seen_q != expected_q) || !inv_ok_q;

    if (fire) begin
      unique case (cmd_i.kind)
        ymr_pkg::CMD_SESSION: begin
          clear      = 1'b1;
          expected_d = '0;
        end
        ymr_pkg::CMD_TICK: begin
          elapsed_d = elapsed_inc;
          if (phase_q == ymr_pkg::PH_CAN) begin
            if (elapsed_inc >= cancel_q) begin
              emit = 1'b1;
              code = ymr_pkg::ST_ERROR;
            end
          end else if (elapsed_inc >= timeout_q) begin
            emit = 1'b1;
            // only the CRC low byte missing: judge on checksum alone
            if (phase_q == ymr_pkg::PH_BODY && pos_q == PosCrcLo) begin
              code = seq_bad ? ymr_pkg::ST_SEQ :
                     matched_q ? ymr_pkg::ST_OK : ymr_pkg::ST_CRC;
            end else begin
              code = ymr_pkg::ST_TIMEOUT;
            end
          end
        end
        default: begin  // received byte
          unique case (phase_q)
            ymr_pkg::PH_HEADER: begin
              if (cmd_i.is_soh) begin
                start_body = 1'b1;
                pos_d      = PosSeen;
                elapsed_d  = '0;
              end else if (cmd_i.is_eot) begin
                emit = 1'b1;
                code = ymr_pkg::ST_EOT;
              end else if (cmd_i.is_can) begin
                start_can = 1'b1;
                elapsed_d = '0;
              end else begin
                emit = 1'b1;
                code = ymr_pkg::ST_ERROR;
              end
            end
            ymr_pkg::PH_CAN: begin
              emit = 1'b1;
              code = cmd_i.is_can ? ymr_pkg::ST_CANCEL : ymr_pkg::ST_ERROR;
            end
            default: begin  // frame body
              if (pos_q == PosSeen) begin
                seen_d = cmd_i.rx_byte;
                pos_d  = PosInv;
              end else if (pos_q == PosInv) begin
                inv_ok_d = (8'(seen_q + cmd_i.rx_byte) == 8'hFF);
                pos_d    = pos_q + 1'b1;
              end else if (pos_q < PosCrcHi) begin
                crc_d              = ymr_pkg::crc_byte(crc_q, cmd_i.rx_byte);
                sum_d              = sum_q + cmd_i.rx_byte;
                pos_d              = pos_q + 1'b1;
                res_push_o         = 1'b1;
                res_o.result_kind  = 1'b0;
                res_o.payload_byte = cmd_i.rx_byte;
                res_o.status_code  = ymr_pkg::ST_OK;
                res_o.block_number = expected_q;
              end else if (pos_q == PosCrcHi) begin
                crc_hi_d  = cmd_i.rx_byte;
                matched_d = (sum_q == cmd_i.rx_byte);
                pos_d     = pos_q + 1'b1;
              end else begin
                emit = 1'b1;
                code = seq_bad ? ymr_pkg::ST_SEQ :
                       ((crc_q == {crc_hi_q, cmd_i.rx_byte}) || matched_q) ?
                       ymr_pkg::ST_OK : ymr_pkg::ST_CRC;
              end
            end
          endcase
        end
      endcase
    end

    if (emit) begin
      clear              = 1'b1;
      res_push_o         = 1'b1;
      res_o.result_kind  = 1'b1;
      res_o.payload_byte = '0;
      res_o.status_code  = code;
      res_o.block_number = expected_q;
      if (code == ymr_pkg::ST_OK) begin
        expected_d = expected_q + 8'd1;
      end
    end

    if (clear) begin
      pos_d     = '0;
      seen_d    = '0;
      inv_ok_d  = 1'b0;
      crc_d     = '0;
      sum_d     = '0;
      matched_d = 1'b0;
      crc_hi_d  = '0;
      elapsed_d = '0;
    end
  end

  // Phase next state
  always_comb begin
    phase_d = phase_q;
    if (clear) begin
      phase_d = ymr_pkg::PH_HEADER;
    end else if (start_body) begin
      phase_d = ymr_pkg::PH_BODY;
    end else if (start_can) begin
      phase_d = ymr_pkg::PH_CAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ymr_pkg::TIMEOUT_RESET;
      cancel_q  <= ymr_pkg::CANCEL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ymr_pkg::REG_PACKET_TIMEOUT: timeout_q <= cfg_wdata_i;
        ymr_pkg::REG_CANCEL_WAIT:    cancel_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ymr_pkg::PH_HEADER;
      pos_q      <= '0;
      expected_q <= '0;
      seen_q     <= '0;
      inv_ok_q   <= 1'b0;
      crc_q      <= '0;
      sum_q      <= '0;
      matched_q  <= 1'b0;
      crc_hi_q   <= '0;
      elapsed_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      expected_q <= expected_d;
      seen_q     <= seen_d;
      inv_ok_q   <= inv_ok_d;
      crc_q      <= crc_d;
      sum_q      <= sum_d;
      matched_q  <= matched_d;
      crc_hi_q   <= crc_hi_d;
      elapsed_q  <= elapsed_d;
    end
  end

endmodule

>>> rtl/ymodem_packet_receiver.sv
// YMODEM receiver for 128-byte SOH packets. Feed it received UART bytes,
// one-millisecond ticks and new-session requests through the push side; it
// hands back one transaction per data byte (passed through as it arrives)
// and one status transaction that closes every packet attempt (OK, timeout,
// end of transfer, cancel, error, sequence error, CRC error). Keep the data
// bytes of a packet only when its status is OK. A packet passes on a
// CRC-16/XMODEM match, or failing that on an 8-bit checksum taken from the
// CRC high byte. Throughput is one transaction per clock: the front decodes
// each item into a 2-entry command queue, the engine retires one command a
// cycle (byte-wide CRC unrolled in one step) into a 2-entry result queue.
// A result is registered in the command queue, then in the result queue,
// before it reaches the outputs. The engine stalls only while the result
// queue is full. The user must write the timeout registers only while the
// block is idle (not enforced by the block); reset needs no clearing pass.
module ymodem_packet_receiver #(
  parameter int unsigned DataBytes  = ymr_pkg::DATA_BYTES,
  parameter int unsigned QueueDepth = ymr_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input queue side
  input  logic                            push,
  output logic                            full,
  input  ymr_pkg::ymr_in_t                in_i,
  // result queue side
  output logic                            empty,
  input  logic                            pop,
  output ymr_pkg::ymr_out_t               out_o,
  // register writes
  input  logic                            cfg_we_i,
  input  logic [ymr_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ymr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic              cmd_valid, cmd_push, cmd_full, cmd_empty, cmd_pop;
  ymr_pkg::ymr_cmd_t cmd_in, cmd_out;
  logic              res_push, res_full;
  ymr_pkg::ymr_out_t res;

  // Front: decode operation, drop the unused code
  ymr_front u_front (
    .item_i      (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in)
  );

  // Accept whenever the command queue has room; invalid codes vanish here
  assign full     = cmd_full;
  assign cmd_push = push && cmd_valid;

  ymr_fifo #(
    .Width (ymr_pkg::CMD_W),
    .Depth (QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // Engine: framing, CRC/checksum, block sequencing, timers
  ymr_back #(
    .DataBytes (DataBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue decouples the consumer from the engine
  ymr_fifo #(
    .Width (ymr_pkg::OUT_W),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_o),
    .empty_o (empty)
  );

endmodule

>>> tb/ymodem_packet_receiver_checker.sv
module ymodem_packet_receiver_checker
  import ymr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic                   full_i,
  input  ymr_in_t                in_i,
  input  logic                   empty_i,
  input  logic                   pop_i,
  input  ymr_out_t               out_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  // register copies
  logic [15:0] frame_limit_ms;
  logic [15:0] can_limit_ms;

  // receiver state
  ymr_phase_e  rx_phase;
  int unsigned rx_pos;
  logic [7:0]  blk_expected;
  logic [7:0]  blk_seen;
  logic        inverse_ok;
  logic        sum_ok;
  logic [15:0] crc_acc;
  logic [7:0]  sum_acc;
  logic [7:0]  crc_hi;
  logic [15:0] idle_ms;

  ymr_out_t    results_due[$];
  int unsigned mismatches;

  // CRC-16/XMODEM, one bit at a time, MSB first
  function automatic logic [15:0] crc16_xmodem(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    acc = crc;
    for (int k = 7; k >= 0; k--) begin
      if (acc[15] ^ b[k]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

  function automatic void drop_frame();
    rx_phase   = PH_HEADER;
    rx_pos     = 0;
    blk_seen   = '0;
    inverse_ok = 1'b0;
    crc_acc    = '0;
    sum_acc    = '0;
    sum_ok     = 1'b0;
    crc_hi     = '0;
    idle_ms    = '0;
  endfunction

  function automatic ymr_out_t close_attempt(ymr_status_e code);
    ymr_out_t r;
    r              = '0;
    r.result_kind  = 1'b1;
    r.status_code  = code;
    r.block_number = blk_expected;
    drop_frame();
    return r;
  endfunction

  function automatic ymr_out_t judge_frame(logic crc_ok);
    ymr_status_e code;
    ymr_out_t    r;
    if (blk_seen != blk_expected || !inverse_ok) begin
      code = ST_SEQ;
    end else if (crc_ok || sum_ok) begin
      code = ST_OK;
    end else begin
      code = ST_CRC;
    end
    r = close_attempt(code);
    if (code == ST_OK) begin
      blk_expected = blk_expected + 8'd1;
    end
    return r;
  endfunction

  // advance the receiver by one transaction; returns 1 when it yields a result
  function automatic logic receive_item(ymr_in_t item, output ymr_out_t res);
    logic [7:0] b;
    b   = item.rx_byte;
    res = '0;
    case (item.operation)
      OP_SESSION: begin
        blk_expected = '0;
        drop_frame();
      end
      OP_TICK: begin
        if (idle_ms != 16'hFFFF) begin
          idle_ms = idle_ms + 16'd1;
        end
        if (rx_phase == PH_CAN) begin
          if (idle_ms >= can_limit_ms) begin
            res = close_attempt(ST_ERROR);
            return 1'b1;
          end
        end else if (idle_ms >= frame_limit_ms) begin
          // only the CRC low byte missing: checksum decides
          if (rx_phase == PH_BODY && rx_pos == DATA_BYTES + 4) begin
            res = judge_frame(1'b0);
          end else begin
            res = close_attempt(ST_TIMEOUT);
          end
          return 1'b1;
        end
      end
      OP_BYTE: begin
        if (rx_phase == PH_HEADER) begin
          if (b == BYTE_SOH) begin
            rx_phase = PH_BODY;
            rx_pos   = 1;
            idle_ms  = '0;
          end else if (b == BYTE_CAN) begin
            rx_phase = PH_CAN;
            idle_ms  = '0;
          end else if (b == BYTE_EOT) begin
            res = close_attempt(ST_EOT);
            return 1'b1;
          end else begin
            res = close_attempt(ST_ERROR);
            return 1'b1;
          end
        end else if (rx_phase == PH_CAN) begin
          if (b == BYTE_CAN) begin
            res = close_attempt(ST_CANCEL);
          end else begin
            res = close_attempt(ST_ERROR);
          end
          return 1'b1;
        end else if (rx_pos == 1) begin
          blk_seen = b;
          rx_pos   = 2;
        end else if (rx_pos == 2) begin
          inverse_ok = (8'(blk_seen + b) == 8'hFF);
          rx_pos     = 3;
        end else if (rx_pos < DATA_BYTES + 3) begin
          crc_acc            = crc16_xmodem(crc_acc, b);
          sum_acc            = sum_acc + b;
          rx_pos             = rx_pos + 1;
          res.payload_byte   = b;
          res.status_code    = ST_OK;
          res.block_number   = blk_expected;
          return 1'b1;
        end else if (rx_pos == DATA_BYTES + 3) begin
          crc_hi = b;
          sum_ok = (sum_acc == b);
          rx_pos = rx_pos + 1;
        end else begin
          res = judge_frame(crc_acc == {crc_hi, b});
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void compare_result(ymr_out_t want, ymr_out_t got);
    if (got.result_kind !== want.result_kind) begin
      $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
      mismatches++;
    end
    if (got.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %02h, got %02h", want.payload_byte, got.payload_byte);
      mismatches++;
    end
    if (got.status_code !== want.status_code) begin
      $error("status_code: expected %0d, got %0d", want.status_code, got.status_code);
      mismatches++;
    end
    if (got.block_number !== want.block_number) begin
      $error("block_number: expected %02h, got %02h", want.block_number, got.block_number);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ymr_out_t predicted;
    if (!rst_ni) begin
      frame_limit_ms = TIMEOUT_RESET;
      can_limit_ms   = CANCEL_RESET;
      blk_expected   = '0;
      drop_frame();
      results_due.delete();
      mismatches     = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PACKET_TIMEOUT: frame_limit_ms = cfg_wdata_i;
          REG_CANCEL_WAIT:    can_limit_ms   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: kind %0d byte %02h status %0d block %02h",
                 out_i.result_kind, out_i.payload_byte, out_i.status_code,
                 out_i.block_number);
          mismatches++;
        end else begin
          compare_result(results_due.pop_front(), out_i);
        end
      end
      if (push_i && !full_i) begin
        if (receive_item(in_i, predicted)) begin
          results_due.push_back(predicted);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= results_due.size();
    end
  end

endmodule

>>> tb/ymodem_packet_receiver_test.sv
module ymodem_packet_receiver_test;
  import ymr_pkg::*;

  // ops beyond the package enum: the unused code is accepted and ignored
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  // cycles to wait after the last expected result before touching registers
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 50_000;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned STEADY_FRAMES = 2;

  // register settings per random phase (index 0 is the rightmost entry);
  // covers zero, one and all-ones on both registers
  localparam int unsigned PHASES = 7;
  localparam logic [PHASES-1:0][15:0] FRAME_PLAN =
    {16'd150, 16'd20, 16'd0, 16'hFFFF, 16'd300, 16'd1, 16'd7};
  localparam logic [PHASES-1:0][15:0] CAN_PLAN =
    {16'd9, 16'd2, 16'd0, 16'hFFFF, 16'd40, 16'd1, 16'd4};

  // how a generated SOH frame is shaped
  typedef enum {
    FR_GOOD,        // correct block, inverse and CRC
    FR_SUM_ONLY,    // CRC wrong, checksum in the CRC high byte slot
    FR_BAD_CRC,     // neither CRC nor checksum match
    FR_BAD_BLOCK,   // block number off, inverse consistent
    FR_BAD_INVERSE, // inverse does not complement block number
    FR_LATE_CRC,    // CRC low byte never arrives, ticks run out
    FR_STALLED,     // frame cut short, ticks run out
    FR_RESTARTED    // frame cut short by a new session
  } frame_kind_e;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   push        = 1'b0;
  logic                   full;
  ymr_in_t                in_i        = '0;
  logic                   empty;
  logic                   pop         = 1'b0;
  ymr_out_t               out_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles      = 0;
  int unsigned items_sent  = 0;
  int unsigned frames_sent = 0;

  // sender-side view of the link: what it last programmed and the block
  // number it believes the receiver wants next
  logic [15:0] frame_limit = TIMEOUT_RESET;
  logic [15:0] can_limit   = CANCEL_RESET;
  logic [7:0]  next_blk    = '0;
  // no idling on either side while set
  bit          steady      = 1'b0;

  ymodem_packet_receiver u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  ymodem_packet_receiver_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_i         (in_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_i        (out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake or a result that never shows ends here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ymodem_packet_receiver_test: FAIL");
      $finish;
    end
  end

  // result side: stall about 17% of cycles unless in the steady stretch
  always @(posedge clk_i) begin
    pop <= steady || ($urandom_range(99) >= 17);
  end

  // sender-side CRC for building frames
  function automatic logic [15:0] xmodem_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {b, 8'h00};
    repeat (8) begin
      acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
    end
    return acc;
  endfunction

  // One transaction on the push side. push is left high on return so a
  // following item goes out back to back; anything that pauses the sender
  // drops push itself.
  task automatic send_item(logic [1:0] op, logic [7:0] b);
    if (!steady && $urandom_range(99) < 17) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= {op, b};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (op != OP_UNUSED) begin
      items_sent++;
    end
  endtask

  // stop sending and wait until every predicted result has been taken;
  // the extra cycles flush items that produce nothing
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(ymr_reg_e idx, logic [15:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_PACKET_TIMEOUT) begin
      frame_limit = value;
    end else begin
      can_limit = value;
    end
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(OP_TICK, 8'($urandom));
  endtask

  // SOH frame with random data, bent according to how
  task automatic send_frame(frame_kind_e how);
    logic [7:0]  body[$];
    logic [7:0]  blk;
    logic [7:0]  inv;
    logic [7:0]  sum;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  d;
    logic [15:0] crc;
    int unsigned cut;
    int unsigned spare_ticks;
    // running out the clock on a frame is only practical with short limits
    if ((how == FR_LATE_CRC || how == FR_STALLED) && frame_limit > 400) begin
      how = FR_GOOD;
    end
    blk = next_blk;
    inv = ~next_blk;
    if (how == FR_BAD_BLOCK) begin
      blk = next_blk + 8'($urandom_range(1, 255));
      inv = ~blk;
    end
    if (how == FR_BAD_INVERSE) begin
      inv = inv ^ 8'($urandom_range(1, 255));
    end
    body.push_back(blk);
    body.push_back(inv);
    crc = '0;
    sum = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      d = 8'($urandom);
      body.push_back(d);
      crc = xmodem_crc_step(crc, d);
      sum = sum + d;
    end
    case (how)
      FR_SUM_ONLY: hi = sum;
      FR_BAD_CRC:  hi = sum ^ 8'($urandom_range(1, 255));
      FR_LATE_CRC: hi = $urandom_range(1) ? sum : (sum ^ 8'($urandom_range(1, 255)));
      default:     hi = crc[15:8];
    endcase
    lo = crc[7:0];
    if (how == FR_SUM_ONLY || how == FR_BAD_CRC) begin
      lo = 8'($urandom);
      if ({hi, lo} == crc) begin
        lo = lo ^ 8'h01;
      end
    end
    body.push_back(hi);
    body.push_back(lo);

    case (how)
      FR_LATE_CRC:               cut = body.size() - 1;
      FR_STALLED, FR_RESTARTED:  cut = $urandom_range(0, body.size() - 2);
      default:                   cut = body.size();
    endcase
    // a few stray ticks inside a frame, well short of a long limit
    spare_ticks = (frame_limit > 200 && cut == body.size()) ? 3 : 0;

    send_item(OP_BYTE, BYTE_SOH);
    for (int i = 0; i < cut; i++) begin
      if (spare_ticks != 0 && $urandom_range(31) == 0) begin
        send_ticks(1);
        spare_ticks--;
      end
      send_item(OP_BYTE, body[i]);
    end

    case (how)
      FR_LATE_CRC, FR_STALLED: send_ticks((frame_limit == 0) ? 1 : frame_limit);
      FR_RESTARTED: begin
        send_item(OP_SESSION, 8'($urandom));
        next_blk = '0;
      end
      default: ;
    endcase
    if (how == FR_GOOD || how == FR_SUM_ONLY || (how == FR_LATE_CRC && hi == sum)) begin
      next_blk = next_blk + 8'd1;
    end
  endtask

  // one randomly picked piece of traffic; frames dominate, shapes rotate
  task automatic run_scenario();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(99);
    b    = 8'($urandom);
    if (pick < 50) begin
      send_frame(frame_kind_e'(frames_sent % 8));
      frames_sent++;
    end else if (pick < 56) begin
      send_item(OP_BYTE, BYTE_EOT);
    end else if (pick < 62) begin
      send_item(OP_BYTE, BYTE_CAN);
      send_item(OP_BYTE, BYTE_CAN);
    end else if (pick < 67) begin
      send_item(OP_BYTE, BYTE_CAN);
      send_item(OP_BYTE, b);
    end else if (pick < 73) begin
      // CAN followed by silence; with a long wait, finish with a real CAN
      send_item(OP_BYTE, BYTE_CAN);
      if (can_limit <= 400) begin
        send_ticks((can_limit == 0) ? 1 : can_limit);
      end else begin
        send_ticks($urandom_range(1, 5));
        send_item(OP_BYTE, BYTE_CAN);
      end
    end else if (pick < 82) begin
      // idle line while waiting for a header
      if (frame_limit <= 400) begin
        send_ticks($urandom_range(1, frame_limit + 1));
      end else begin
        send_ticks($urandom_range(1, 50));
      end
    end else if (pick < 90) begin
      // stray header byte; an SOH by chance is abandoned right away
      send_item(OP_BYTE, b);
      if (b == BYTE_SOH) begin
        send_item(OP_SESSION, 8'($urandom));
        next_blk = '0;
      end
    end else if (pick < 93) begin
      send_item(OP_UNUSED, b);
    end else if (pick < 97) begin
      send_item(OP_SESSION, b);
      next_blk = '0;
    end else begin
      // sender holds off until the receiver has drained
      settle();
    end
  endtask

  initial begin
    int unsigned stop_at;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: header bytes at reset register values
    send_item(OP_BYTE, BYTE_EOT);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, BYTE_CAN);
    send_item(OP_BYTE, BYTE_CAN);
    send_item(OP_BYTE, BYTE_CAN);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_SESSION, 8'h00);

    // zero limits expire on the very first tick in every phase
    write_reg(REG_PACKET_TIMEOUT, 16'd0);
    write_reg(REG_CANCEL_WAIT, 16'd0);
    send_ticks(1);
    send_item(OP_BYTE, BYTE_CAN);
    send_ticks(1);
    send_item(OP_BYTE, BYTE_SOH);
    send_ticks(1);

    // short limits: header timeout after two ticks, CAN wait after three
    write_reg(REG_PACKET_TIMEOUT, 16'd2);
    write_reg(REG_CANCEL_WAIT, 16'd3);
    send_ticks(2);
    send_item(OP_BYTE, BYTE_CAN);
    send_ticks(3);

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_PACKET_TIMEOUT, FRAME_PLAN[p]);
      write_reg(REG_CANCEL_WAIT, CAN_PLAN[p]);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        run_scenario();
      end
    end

    // back-to-back good frames with no idling anywhere
    write_reg(REG_PACKET_TIMEOUT, TIMEOUT_RESET);
    write_reg(REG_CANCEL_WAIT, CANCEL_RESET);
    steady = 1'b1;
    send_item(OP_SESSION, 8'($urandom));
    next_blk = '0;
    repeat (STEADY_FRAMES) begin
      send_frame($urandom_range(1) ? FR_GOOD : FR_SUM_ONLY);
    end
    steady = 1'b0;

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("ymodem_packet_receiver_test: PASS");
    end else begin
      $display("ymodem_packet_receiver_test: FAIL");
    end
    $finish;
  end

endmodule
